// File: rtl/core/pbcd_pkg.sv
// ----------------------------------------------------------------------------
// pbcd_pkg
// Shared widths, limits and types for the packed BCD to binary unit.
// ----------------------------------------------------------------------------
package pbcd_pkg;

   localparam int BYTE_W     = 8;
   localparam int NIB_W      = 4;
   localparam int VALUE_W    = 54;
   localparam int COUNT_W    = 5;
   localparam int BYTE_COUNT = 8;

   // At most two digits per byte are folded in.
   localparam logic [COUNT_W-1:0] MAX_DIGITS = COUNT_W'(2 * BYTE_COUNT);

   // Nibbles of this value or more are not decimal digits.
   localparam logic [NIB_W-1:0] DIGIT_LIMIT = NIB_W'(10);

   // Running state of one digit run.
   typedef struct packed {
      logic [VALUE_W-1:0] acc;
      logic [COUNT_W-1:0] count;
      logic               stopped;
   } run_state_type;

endpackage

// File: rtl/core/pbcd_fold.sv
// ----------------------------------------------------------------------------
// pbcd_fold
// Folds one BCD nibble into the running state: acc * 10 + digit.
// ----------------------------------------------------------------------------
module pbcd_fold (
   input  pbcd_pkg::run_state_type      run_cur,
   input  logic                         clear,
   input  logic                         skip_mode,
   input  logic [pbcd_pkg::NIB_W-1:0]   nibble,
   output pbcd_pkg::run_state_type      run_next
);

   pbcd_pkg::run_state_type  base;
   logic [pbcd_pkg::VALUE_W-1:0] acc_x10;

   always_comb begin
      base = clear ? '0 : run_cur;
   end

   // acc * 8 + acc * 2 + digit, kept to the value width.
   assign acc_x10 = {base.acc[pbcd_pkg::VALUE_W-4:0], 3'b000}
                  + {base.acc[pbcd_pkg::VALUE_W-2:0], 1'b0}
                  + {{(pbcd_pkg::VALUE_W-pbcd_pkg::NIB_W){1'b0}}, nibble};

   always_comb begin
      run_next = base;
      priority if (base.stopped) begin
         run_next = base;
      end else if (nibble >= pbcd_pkg::DIGIT_LIMIT) begin
         run_next.stopped = !skip_mode;
      end else if (base.count >= pbcd_pkg::MAX_DIGITS) begin
         run_next = base;
      end else begin
         run_next.acc   = acc_x10;
         run_next.count = base.count + pbcd_pkg::COUNT_W'(1);
      end
   end

endmodule

// File: rtl/core/packed_bcd_to_binary_unit.sv
// ----------------------------------------------------------------------------
// packed_bcd_to_binary_unit
// Converts a packed BCD number, fed one byte per beat, into binary.
// ----------------------------------------------------------------------------
// Each request beat carries one packed BCD byte, high nibble first. The byte
// is held in a nibble shift register and one digit is folded into a 54-bit
// accumulator per clock (acc * 10 + digit): the high nibble in state HIGH,
// then the low nibble in state LOW. The next beat is taken in the cycle that
// folds the low nibble, so a new byte enters as the last one finishes. A beat
// marked first clears the accumulator, digit count and stop flag before its
// digits are folded; a beat marked last produces one response beat with the
// value and the digit count. When the skip mode bit (mode_ff, written via
// the CSR port) is 0, the first non-decimal nibble ends the run until the
// next first beat; when it is 1, such nibbles are passed over. At most 16
// digits are folded in. Responses sit in an output register; if a last beat
// completes while an earlier response is still waiting, the unit holds that
// result and stalls the request side until the response register frees up.
// ----------------------------------------------------------------------------
module packed_bcd_to_binary_unit (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pbcd_pkg::BYTE_W-1:0]    req_bcd_byte,
   input  logic                           req_first_byte,
   input  logic                           req_last_byte,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pbcd_pkg::VALUE_W-1:0]   rsp_binary_value,
   output logic [pbcd_pkg::COUNT_W-1:0]   rsp_digit_total
);

   // IDLE waits for a beat, HIGH folds the high nibble, LOW folds the low
   // nibble (and may take the next beat), HOLD waits to hand off a result.
   typedef enum logic [1:0] {
      IDLE,
      HIGH,
      LOW,
      HOLD
   } state_type;

   state_type                      state_ff,  state_in;
   logic [pbcd_pkg::BYTE_W-1:0]    byte_ff,   byte_in;
   logic                           first_ff,  first_in;
   logic                           last_ff,   last_in;
   logic                           mode_ff;
   pbcd_pkg::run_state_type        run_ff,    run_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pbcd_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [pbcd_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   pbcd_pkg::run_state_type        fold_next;
   logic                           out_free;
   logic                           accept;

   // The fold unit always works on the top nibble of the shift register.
   pbcd_fold u_fold (
      .run_cur   (run_ff),
      .clear     (state_ff == HIGH && first_ff),
      .skip_mode (mode_ff),
      .nibble    (byte_ff[pbcd_pkg::BYTE_W-1 -: pbcd_pkg::NIB_W]),
      .run_next  (fold_next)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // A beat can enter when idle, or while the low nibble is folded unless
   // that nibble ends a number whose result cannot be stored yet.
   always_comb begin
      unique case (state_ff)
         IDLE:    req_ready = 1'b1;
         LOW:     req_ready = !last_ff || out_free;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in = HIGH;
            end
         end
         HIGH: begin
            run_in   = fold_next;
            byte_in  = {byte_ff[pbcd_pkg::BYTE_W-pbcd_pkg::NIB_W-1:0],
                        {pbcd_pkg::NIB_W{1'b0}}};
            state_in = LOW;
         end
         LOW: begin
            run_in = fold_next;
            if (last_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fold_next.acc;
               rsp_count_in = fold_next.count;
            end
            if (last_ff && !out_free) begin
               state_in = HOLD;
            end else if (accept) begin
               state_in = HIGH;
            end else begin
               state_in = IDLE;
            end
         end
         HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = run_ff.acc;
               rsp_count_in = run_ff.count;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      if (accept) begin
         byte_in  = req_bcd_byte;
         first_in = req_first_byte;
         last_in  = req_last_byte;
      end
   end

   // Control state is reset; the payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         run_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
      byte_ff      <= byte_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binary_value = rsp_value_ff;
   assign rsp_digit_total  = rsp_count_ff;

endmodule

// File: rtl/core/pbcd_checker.sv
// ----------------------------------------------------------------------------
// pbcd_checker
// Port-level checks for the packed BCD to binary unit, bound to the top.
// ----------------------------------------------------------------------------
module pbcd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [pbcd_pkg::VALUE_W-1:0]   rsp_binary_value,
   input  logic [pbcd_pkg::COUNT_W-1:0]   rsp_digit_total
);

   // A waiting response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_binary_value)
                                  && $stable(rsp_digit_total))
      else $error("response changed while stalled");

   // The digit total never exceeds MAX_DIGITS (two digits per byte position).
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_total <= pbcd_pkg::MAX_DIGITS)
      else $error("digit total above limit");

   // A number with no digits is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_total == '0 |-> rsp_binary_value == '0)
      else $error("nonzero value with no digits");

   // The cycle after a beat is taken, the high nibble is being folded.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("beat taken during high nibble fold");

   // Reset empties the response register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind packed_bcd_to_binary_unit pbcd_checker u_pbcd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_binary_value (rsp_binary_value),
   .rsp_digit_total  (rsp_digit_total)
);
